// ===== design/pcpl_pkg.sv =====
`timescale 1ns / 1ps

package pcpl_pkg;

	// Field widths fixed by the stream format
	localparam int TOTAL_W = 8;
	localparam int COUNT_W = 64;
	localparam int S_DATA_W = 3 * TOTAL_W;
	localparam int M_DATA_W = COUNT_W;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_UPDATE,
		ST_FINISH
	} pcpl_state_t;

	// Commands from the sequencer to the scratch row
	typedef struct packed {
		logic rd_en;      // fetch row[m] and row[m - j]
		logic wr_clear;   // write the part-size-zero row value
		logic clear_one;  // value written by a clear is one (entry zero)
		logic wr_sum;     // write row[m] + row[m - j] back to row[m]
	} row_cmd_t;

endpackage

// ===== design/pcpl_row.sv =====
`timescale 1ns / 1ps

module pcpl_row
	import pcpl_pkg::*;
#(
	parameter int MAX_TOTAL = 255
) (
	input  logic                          clk,
	input  row_cmd_t                      cmd,
	input  logic [$clog2(MAX_TOTAL+1)-1:0] addr,      // entry m
	input  logic [$clog2(MAX_TOTAL+1)-1:0] addr_back, // entry m - j
	output logic [COUNT_W-1:0]            sum
);

	logic [COUNT_W-1:0] row_mem [0:MAX_TOTAL];
	logic [COUNT_W-1:0] rd_cur_q;
	logic [COUNT_W-1:0] rd_back_q;
	logic [COUNT_W-1:0] wr_data;

	// Shared adder: one row entry per update
	assign sum = rd_cur_q + rd_back_q;

	always_comb begin
		if (cmd.wr_clear) begin
			wr_data = cmd.clear_one ? COUNT_W'(1) : '0;
		end else begin
			wr_data = sum;
		end
	end

	// Write one entry, read two entries with registered data
	always_ff @(posedge clk) begin
		if (cmd.wr_clear || cmd.wr_sum) begin
			row_mem[addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_cur_q  <= row_mem[addr];
			rd_back_q <= row_mem[addr_back];
		end
	end

endmodule

// ===== design/partition_count_by_part_limit_unit.sv =====
`timescale 1ns / 1ps
// Clears row entries 0..n, then for each part size j = 1..kmax reads and updates entries
// m = j..n through the single adder and the one write port of the scratch row, then loads
// the result; n is the saturated total, kmax the larger clamped limit. A new item is taken
// only while idle, once the prior result is loaded; an m_tready stall holds the finish state.
// Reset: arst_n clears the sequencer and the output valid; the scratch row is not
// cleared, since every query rewrites the entries it reads before reading them.
module partition_count_by_part_limit_unit
	import pcpl_pkg::*;
#(
	parameter int MAX_TOTAL = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [7:0] total, [15:8] upper_limit, [23:16] lower_limit
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // [63:0] count_difference
);

	localparam int AW = $clog2(MAX_TOTAL + 1);
	localparam int CW = (AW > TOTAL_W) ? AW : TOTAL_W;

	pcpl_state_t state_q, state_d;
	row_cmd_t    cmd;

	logic [AW-1:0]      n_q, ku_q, kl_q, kmax_q;
	logic [AW-1:0]      j_q, m_q;
	logic [COUNT_W-1:0] cnt_u_q, cnt_l_q;
	logic [COUNT_W-1:0] sum;
	logic [COUNT_W-1:0] m_tdata_q;
	logic               m_tvalid_q;

	logic [CW-1:0] in_n, in_ku, in_kl, in_kmax;
	logic          s_fire;
	logic          last_m, last_j, out_free;

	// Saturate the total and clamp both limits to it
	always_comb begin
		in_n = CW'(s_tdata[TOTAL_W-1:0]);
		if (in_n > CW'(MAX_TOTAL)) begin
			in_n = CW'(MAX_TOTAL);
		end
		in_ku = CW'(s_tdata[2*TOTAL_W-1:TOTAL_W]);
		if (in_ku > in_n) begin
			in_ku = in_n;
		end
		in_kl = CW'(s_tdata[3*TOTAL_W-1:2*TOTAL_W]);
		if (in_kl > in_n) begin
			in_kl = in_n;
		end
		in_kmax = (in_ku > in_kl) ? in_ku : in_kl;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign last_m   = (m_q == n_q);
	assign last_j   = (j_q == kmax_q);
	assign out_free = !m_tvalid_q || m_tready;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and row commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.clear_one = (m_q == '0);
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.wr_clear = 1'b1;
				if (last_m) begin
					state_d = (kmax_q == '0) ? ST_FINISH : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.wr_sum = 1'b1;
				state_d    = (last_m && last_j) ? ST_FINISH : ST_READ;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance the part size and row position, sample counts at the limits
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					n_q     <= AW'(in_n);
					ku_q    <= AW'(in_ku);
					kl_q    <= AW'(in_kl);
					kmax_q  <= AW'(in_kmax);
					m_q     <= '0;
					j_q     <= AW'(1);
					cnt_u_q <= (in_ku == '0 && in_n == '0) ? COUNT_W'(1) : '0;
					cnt_l_q <= (in_kl == '0 && in_n == '0) ? COUNT_W'(1) : '0;
				end
			end
			ST_CLEAR: begin
				m_q <= last_m ? AW'(1) : m_q + AW'(1);
			end
			ST_UPDATE: begin
				if (last_m) begin
					if (j_q == ku_q) begin
						cnt_u_q <= sum;
					end
					if (j_q == kl_q) begin
						cnt_l_q <= sum;
					end
					j_q <= j_q + AW'(1);
					m_q <= j_q + AW'(1);
				end else begin
					m_q <= m_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load the difference once the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= cnt_u_q - cnt_l_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	pcpl_row #(
		.MAX_TOTAL(MAX_TOTAL)
	) u_row (
		.clk      (clk),
		.cmd      (cmd),
		.addr     (m_q),
		.addr_back(m_q - j_q),
		.sum      (sum)
	);

	// Row position stays inside the current pass
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (m_q <= n_q && j_q <= m_q && j_q <= kmax_q))
		else $error("row position out of range");

	// An accepted item starts the clearing pass
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == ST_CLEAR && m_q == '0))
		else $error("accepted item did not start clearing");

	// Last update of the last part size ends the pass
	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && last_m && last_j) |=> (state_q == ST_FINISH))
		else $error("pass did not end after last update");

	// A new result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready && state_q == ST_FINISH) |=> $stable(m_tdata_q))
		else $error("pending result overwritten");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pcpl_pkg::*;

	localparam int ROW_MAX = 255;  // largest total the scratch row holds

	// One accepted query with the difference it should produce
	typedef struct {
		logic [7:0]         total;
		logic [7:0]         upper;
		logic [7:0]         lower;
		logic [COUNT_W-1:0] difference;
	} query_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;  // [7:0] total, [15:8] upper_limit, [23:16] lower_limit
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;       // [63:0] count_difference

	query_t pending_queries[$];
	int     mismatch_count = 0;
	bit     steady_flow = 1'b0;  // no idling on either side while set

	partition_count_by_part_limit_unit #(
		.MAX_TOTAL(ROW_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// Build the partition row bottom up and sample the count for n at both limits
	function automatic logic [COUNT_W-1:0] partition_difference(logic [7:0] total,
			logic [7:0] upper, logic [7:0] lower);
		logic [COUNT_W-1:0] row [0:ROW_MAX];
		logic [COUNT_W-1:0] upper_count;
		logic [COUNT_W-1:0] lower_count;
		int n;
		int ku;
		int kl;
		int kmax;
		n = (total > ROW_MAX) ? ROW_MAX : total;
		ku = (upper > n) ? n : upper;
		kl = (lower > n) ? n : lower;
		kmax = (ku > kl) ? ku : kl;
		row[0] = COUNT_W'(1);
		for (int m = 1; m <= n; m++)
			row[m] = '0;
		upper_count = (ku == 0) ? row[n] : '0;
		lower_count = (kl == 0) ? row[n] : '0;
		for (int j = 1; j <= kmax; j++) begin
			for (int m = j; m <= n; m++)
				row[m] = row[m] + row[m - j];
			if (j == ku)
				upper_count = row[n];
			if (j == kl)
				lower_count = row[n];
		end
		return upper_count - lower_count;
	endfunction

	// Offer one query, idling first now and then, and record it once transferred
	task automatic send_query(input logic [7:0] total, input logic [7:0] upper,
			input logic [7:0] lower);
		query_t q;
		if (!steady_flow && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 9)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {lower, upper, total};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		q.total = total;
		q.upper = upper;
		q.lower = lower;
		q.difference = partition_difference(total, upper, lower);
		pending_queries.insert(pending_queries.size(), q);
	endtask

	// Drop valid and hold until every outstanding result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_queries.size() != 0)
			@(posedge clk);
	endtask

	// Check each result transfer against the oldest query, then pick the next ready
	always @(posedge clk) begin
		query_t q;
		if (m_tvalid && m_tready) begin
			if (pending_queries.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
			end else begin
				q = pending_queries.pop_front();
				if (m_tdata !== q.difference) begin
					mismatch_count++;
					$display("%0t: n=%0d upper=%0d lower=%0d expected %h, actual %h",
						$time, q.total, q.upper, q.lower, q.difference, m_tdata);
				end
			end
		end
		m_tready <= steady_flow || ($urandom_range(0, 99) >= 9);
	end

	// Total zero has exactly one partition whatever the limits
	task automatic test_total_zero();
		send_query(8'd0, 8'd0, 8'd0);
		send_query(8'd0, 8'd255, 8'd0);
		send_query(8'd0, 8'd0, 8'd255);
	endtask

	// Limit zero counts nothing for n above zero
	task automatic test_zero_limits();
		send_query(8'd1, 8'd0, 8'd0);
		send_query(8'd1, 8'd1, 8'd0);
		send_query(8'd5, 8'd5, 8'd0);
		send_query(8'd20, 8'd0, 8'd0);
	endtask

	// Limits above n behave as n
	task automatic test_clamping();
		send_query(8'd5, 8'd255, 8'd2);
		send_query(8'd10, 8'd10, 8'd200);
		send_query(8'd12, 8'd128, 8'd64);
		send_query(8'd20, 8'd255, 8'd0);
	endtask

	// A smaller minuend wraps the difference around
	task automatic test_wraparound();
		send_query(8'd1, 8'd0, 8'd1);
		send_query(8'd5, 8'd3, 8'd5);
		send_query(8'd10, 8'd2, 8'd7);
		send_query(8'd30, 8'd1, 8'd255);
	endtask

	// Large totals, mostly the largest: passes over the whole scratch row
	task automatic test_largest_total();
		send_query(8'd255, 8'd255, 8'd0);
		send_query(8'd255, 8'd1, 8'd0);
		send_query(8'd255, 8'd0, 8'd1);
		send_query(8'd170, 8'd85, 8'd42);
		send_query(8'd255, 8'd128, 8'd255);
	endtask

	// Random queries: mostly small totals, an occasional large one
	task automatic test_random_queries(input int count);
		logic [7:0] total;
		logic [7:0] upper;
		logic [7:0] lower;
		for (int i = 0; i < count; i++) begin
			total = (i % 16 == 15) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
			upper = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, total + 1));
			lower = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, total + 1));
			send_query(total, upper, lower);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_total_zero();
		test_zero_limits();
		test_clamping();
		test_wraparound();
		wait_drained();
		test_largest_total();
		test_random_queries(50);
		steady_flow = 1'b1;
		test_random_queries(30);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Stop a hung run
	initial begin
		#48_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/pcpl_pkg.sv
design/pcpl_row.sv
design/partition_count_by_part_limit_unit.sv
sim/testbench.sv
